>>> rtl/core/sfpes_pkg.sv
package sfpes_pkg;

   localparam int ADDR_W   = 23;
   localparam int COUNT_W  = 24;
   localparam int LEN_W    = 9;
   localparam int RETRY_W  = 16;
   localparam int ACT_W    = 4;
   localparam int RTYPE_W  = 2;

   localparam int PAGE_LOG     = 8;
   localparam int PAGE_BYTES   = 1 << PAGE_LOG;
   localparam int SECTOR_LOG   = 12;
   localparam int SECTOR_BYTES = 1 << SECTOR_LOG;
   localparam int SROOM_W      = SECTOR_LOG + 1;
   localparam int FLASH_BYTES  = 8388608;

   localparam logic [RETRY_W-1:0] DEFAULT_POLL_LIMIT = 16'd12000;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_POLL_LIMIT = 1'b0;

   localparam logic KIND_REQUEST = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   localparam logic [RTYPE_W-1:0] REQ_WRITE        = 2'd0;
   localparam logic [RTYPE_W-1:0] REQ_WRITE_ERASE  = 2'd1;
   localparam logic [RTYPE_W-1:0] REQ_SECTOR_ERASE = 2'd2;
   localparam logic [RTYPE_W-1:0] REQ_CHIP_ERASE   = 2'd3;

   localparam logic [ACT_W-1:0] ACT_NONE         = 4'd0;
   localparam logic [ACT_W-1:0] ACT_SECTOR_ERASE = 4'd1;
   localparam logic [ACT_W-1:0] ACT_PROGRAM      = 4'd2;
   localparam logic [ACT_W-1:0] ACT_CHIP_ERASE   = 4'd3;
   localparam logic [ACT_W-1:0] ACT_POLL         = 4'd4;
   localparam logic [ACT_W-1:0] ACT_DONE         = 4'd5;
   localparam logic [ACT_W-1:0] ACT_PARAM_ERR    = 4'd6;
   localparam logic [ACT_W-1:0] ACT_TIMEOUT      = 4'd7;
   localparam logic [ACT_W-1:0] ACT_BUS_ERR      = 4'd8;

   typedef struct packed {
      logic               kind;
      logic [RTYPE_W-1:0] request_type;
      logic [ADDR_W-1:0]  start_address;
      logic [COUNT_W-1:0] byte_count;
      logic               busy_req;
      logic               bus_error;
   } req_item_type;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [ADDR_W-1:0] op_address;
      logic [LEN_W-1:0]  op_length;
      logic [ADDR_W-1:0] source_offset;
   } rsp_item_type;

endpackage

>>> rtl/core/sfpes_if.sv
interface sfpes_req_if;
   logic                              valid;
   logic                              ready;
   logic                              kind;
   logic [sfpes_pkg::RTYPE_W-1:0]     request_type;
   logic [sfpes_pkg::ADDR_W-1:0]      start_address;
   logic [sfpes_pkg::COUNT_W-1:0]     byte_count;
   logic                              busy_req;
   logic                              bus_error;

   modport source (
      output valid, kind, request_type, start_address, byte_count, busy_req, bus_error,
      input  ready
   );
   modport sink (
      input  valid, kind, request_type, start_address, byte_count, busy_req, bus_error,
      output ready
   );
endinterface

interface sfpes_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sfpes_pkg::ACT_W-1:0]   action;
   logic [sfpes_pkg::ADDR_W-1:0]  op_address;
   logic [sfpes_pkg::LEN_W-1:0]   op_length;
   logic [sfpes_pkg::ADDR_W-1:0]  source_offset;

   modport source (
      output valid, action, op_address, op_length, source_offset,
      input  ready
   );
   modport sink (
      input  valid, action, op_address, op_length, source_offset,
      output ready
   );
endinterface

>>> rtl/core/sfpes_csr.sv
module sfpes_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sfpes_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [sfpes_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [sfpes_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready,
   output logic [sfpes_pkg::RETRY_W-1:0]       poll_limit
);

   logic [sfpes_pkg::RETRY_W-1:0] poll_limit_ff;
   logic [sfpes_pkg::RETRY_W-1:0] poll_limit_in;
   logic                          hit;

   assign hit        = csr_paddr[sfpes_pkg::CSR_ADDR_W-1] == sfpes_pkg::CSR_IDX_POLL_LIMIT;
   assign csr_pready = 1'b1;

   always_comb begin
      poll_limit_in = poll_limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         poll_limit_in = csr_pwdata[sfpes_pkg::RETRY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_limit_ff <= sfpes_pkg::DEFAULT_POLL_LIMIT;
      end else begin
         poll_limit_ff <= poll_limit_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (hit) begin
         csr_prdata = sfpes_pkg::CSR_DATA_W'(poll_limit_ff);
      end
   end

   assign poll_limit = poll_limit_ff;

endmodule

>>> rtl/core/sfpes_in_stage.sv
module sfpes_in_stage (
   input  logic                    clock,
   input  logic                    reset,
   sfpes_req_if.sink               req_bus,
   input  logic                    take,
   output logic                    item_valid,
   output sfpes_pkg::req_item_type item
);

   logic                    valid_ff;
   logic                    valid_in;
   sfpes_pkg::req_item_type item_ff;
   sfpes_pkg::req_item_type item_in;
   logic                    accept;

   assign req_bus.ready = !valid_ff || take;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in              = 1'b1;
         item_in.kind          = req_bus.kind;
         item_in.request_type  = req_bus.request_type;
         item_in.start_address = req_bus.start_address;
         item_in.byte_count    = req_bus.byte_count;
         item_in.busy_req      = req_bus.busy_req;
         item_in.bus_error     = req_bus.bus_error;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> rtl/core/sfpes_seq.sv
module sfpes_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [sfpes_pkg::RETRY_W-1:0] poll_limit,
   input  logic                          item_valid,
   input  sfpes_pkg::req_item_type       item,
   output logic                          take,
   sfpes_rsp_if.source                   rsp_bus
);

   localparam logic [1:0] PH_IDLE         = 2'd0;
   localparam logic [1:0] PH_WAIT_ERASE   = 2'd1;
   localparam logic [1:0] PH_WAIT_PROGRAM = 2'd2;

   localparam int AW = sfpes_pkg::ADDR_W;
   localparam int CW = sfpes_pkg::COUNT_W;
   localparam int LW = sfpes_pkg::LEN_W;
   localparam int RW = sfpes_pkg::RETRY_W;

   function automatic logic [LW-1:0] chunk_len(
      input logic [AW-1:0] ca,
      input logic [CW-1:0] bl,
      input logic          erase
   );
      logic [LW-1:0]                 page_room;
      logic [sfpes_pkg::SROOM_W-1:0] sector_room;
      logic [LW-1:0]                 len;
      page_room   = LW'(sfpes_pkg::PAGE_BYTES) - LW'(ca[sfpes_pkg::PAGE_LOG-1:0]);
      sector_room = sfpes_pkg::SROOM_W'(sfpes_pkg::SECTOR_BYTES)
                    - sfpes_pkg::SROOM_W'(ca[sfpes_pkg::SECTOR_LOG-1:0]);
      if (bl < CW'(page_room)) begin
         len = bl[LW-1:0];
      end else begin
         len = page_room;
      end
      if (erase && (sfpes_pkg::SROOM_W'(len) > sector_room)) begin
         len = LW'(sector_room);
      end
      return len;
   endfunction

   logic [1:0]              phase_ff, phase_in;
   logic                    erase_ff, erase_in;
   logic [AW-1:0]           op_addr_ff, op_addr_in;
   logic [CW-1:0]           bytes_left_ff, bytes_left_in;
   logic [AW-1:0]           bytes_done_ff, bytes_done_in;
   logic [RW-1:0]           retry_ff, retry_in;
   logic [LW-1:0]           chunk_pend_ff, chunk_pend_in;
   logic                    out_valid_ff, out_valid_in;
   sfpes_pkg::rsp_item_type out_item_ff, out_item_in;

   logic [AW-1:0] sector_mask;
   logic          addr_oor;
   logic          span_oor;
   logic [RW-1:0] retry_next;
   logic          timeout;
   logic [LW-1:0] done_len;
   logic [AW-1:0] ca_new;
   logic [CW-1:0] bl_new;
   logic [AW-1:0] bd_new;
   logic [LW-1:0] len_req;
   logic [LW-1:0] len_next;
   logic [LW-1:0] len_cur;

   assign take = item_valid && (!out_valid_ff || rsp_bus.ready);

   assign sector_mask = ~AW'(sfpes_pkg::SECTOR_BYTES - 1);
   assign addr_oor    = CW'(item.start_address) >= CW'(sfpes_pkg::FLASH_BYTES);
   assign span_oor    = ((CW + 1)'(item.start_address) + (CW + 1)'(item.byte_count))
                        > (CW + 1)'(sfpes_pkg::FLASH_BYTES);
   assign retry_next  = retry_ff + RW'(1);
   assign timeout     = (retry_next == '0) || (retry_next >= poll_limit);
   assign done_len    = (CW'(chunk_pend_ff) > bytes_left_ff) ? bytes_left_ff[LW-1:0]
                                                              : chunk_pend_ff;
   assign ca_new      = op_addr_ff + AW'(done_len);
   assign bd_new      = bytes_done_ff + AW'(done_len);
   assign bl_new      = bytes_left_ff - CW'(done_len);
   assign len_req     = chunk_len(item.start_address, item.byte_count, 1'b0);
   assign len_next    = chunk_len(ca_new, bl_new, erase_ff);
   assign len_cur     = chunk_len(op_addr_ff, bytes_left_ff, erase_ff);

   always_comb begin
      phase_in      = phase_ff;
      erase_in      = erase_ff;
      op_addr_in    = op_addr_ff;
      bytes_left_in = bytes_left_ff;
      bytes_done_in = bytes_done_ff;
      retry_in      = retry_ff;
      chunk_pend_in = chunk_pend_ff;
      out_item_in   = '0;
      out_item_in.action = sfpes_pkg::ACT_NONE;

      if (item.kind == sfpes_pkg::KIND_REQUEST) begin
         if (phase_ff == PH_IDLE) begin
            case (item.request_type)
               sfpes_pkg::REQ_CHIP_ERASE: begin
                  bytes_left_in      = '0;
                  erase_in           = 1'b0;
                  phase_in           = PH_WAIT_ERASE;
                  retry_in           = '0;
                  out_item_in.action = sfpes_pkg::ACT_CHIP_ERASE;
               end
               sfpes_pkg::REQ_SECTOR_ERASE: begin
                  if (addr_oor) begin
                     phase_in           = PH_IDLE;
                     retry_in           = '0;
                     chunk_pend_in      = '0;
                     bytes_left_in      = '0;
                     out_item_in.action = sfpes_pkg::ACT_PARAM_ERR;
                  end else begin
                     bytes_left_in          = '0;
                     erase_in               = 1'b0;
                     phase_in               = PH_WAIT_ERASE;
                     retry_in               = '0;
                     out_item_in.action     = sfpes_pkg::ACT_SECTOR_ERASE;
                     out_item_in.op_address = item.start_address & sector_mask;
                  end
               end
               default: begin
                  if ((item.byte_count == '0) || addr_oor || span_oor) begin
                     phase_in           = PH_IDLE;
                     retry_in           = '0;
                     chunk_pend_in      = '0;
                     bytes_left_in      = '0;
                     out_item_in.action = sfpes_pkg::ACT_PARAM_ERR;
                  end else begin
                     erase_in      = item.request_type == sfpes_pkg::REQ_WRITE_ERASE;
                     op_addr_in    = item.start_address;
                     bytes_left_in = item.byte_count;
                     bytes_done_in = '0;
                     retry_in      = '0;
                     if (item.request_type == sfpes_pkg::REQ_WRITE_ERASE) begin
                        chunk_pend_in          = '0;
                        phase_in               = PH_WAIT_ERASE;
                        out_item_in.action     = sfpes_pkg::ACT_SECTOR_ERASE;
                        out_item_in.op_address = item.start_address & sector_mask;
                     end else begin
                        chunk_pend_in          = len_req;
                        phase_in               = PH_WAIT_PROGRAM;
                        out_item_in.action     = sfpes_pkg::ACT_PROGRAM;
                        out_item_in.op_address = item.start_address;
                        out_item_in.op_length  = len_req;
                     end
                  end
               end
            endcase
         end
      end else if (phase_ff != PH_IDLE) begin
         if (item.bus_error || (item.busy_req && timeout)) begin
            phase_in      = PH_IDLE;
            retry_in      = '0;
            chunk_pend_in = '0;
            bytes_left_in = '0;
            out_item_in.action = item.bus_error ? sfpes_pkg::ACT_BUS_ERR
                                                : sfpes_pkg::ACT_TIMEOUT;
         end else if (item.busy_req) begin
            retry_in           = retry_next;
            out_item_in.action = sfpes_pkg::ACT_POLL;
         end else if (phase_ff == PH_WAIT_PROGRAM) begin
            op_addr_in    = ca_new;
            bytes_done_in = bd_new;
            bytes_left_in = bl_new;
            chunk_pend_in = '0;
            retry_in      = '0;
            if (bl_new == '0) begin
               phase_in           = PH_IDLE;
               out_item_in.action = sfpes_pkg::ACT_DONE;
            end else if (erase_ff && (ca_new[sfpes_pkg::SECTOR_LOG-1:0] == '0)) begin
               phase_in               = PH_WAIT_ERASE;
               out_item_in.action     = sfpes_pkg::ACT_SECTOR_ERASE;
               out_item_in.op_address = ca_new & sector_mask;
            end else begin
               chunk_pend_in             = len_next;
               phase_in                  = PH_WAIT_PROGRAM;
               out_item_in.action        = sfpes_pkg::ACT_PROGRAM;
               out_item_in.op_address    = ca_new;
               out_item_in.op_length     = len_next;
               out_item_in.source_offset = bd_new;
            end
         end else begin
            retry_in = '0;
            if (bytes_left_ff == '0) begin
               phase_in           = PH_IDLE;
               chunk_pend_in      = '0;
               out_item_in.action = sfpes_pkg::ACT_DONE;
            end else begin
               chunk_pend_in             = len_cur;
               phase_in                  = PH_WAIT_PROGRAM;
               out_item_in.action        = sfpes_pkg::ACT_PROGRAM;
               out_item_in.op_address    = op_addr_ff;
               out_item_in.op_length     = len_cur;
               out_item_in.source_offset = bytes_done_ff;
            end
         end
      end
   end

   assign out_valid_in = take || (out_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         erase_ff      <= 1'b0;
         op_addr_ff    <= '0;
         bytes_left_ff <= '0;
         bytes_done_ff <= '0;
         retry_ff      <= '0;
         chunk_pend_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            phase_ff      <= phase_in;
            erase_ff      <= erase_in;
            op_addr_ff    <= op_addr_in;
            bytes_left_ff <= bytes_left_in;
            bytes_done_ff <= bytes_done_in;
            retry_ff      <= retry_in;
            chunk_pend_ff <= chunk_pend_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.action        = out_item_ff.action;
   assign rsp_bus.op_address    = out_item_ff.op_address;
   assign rsp_bus.op_length     = out_item_ff.op_length;
   assign rsp_bus.source_offset = out_item_ff.source_offset;

endmodule

>>> rtl/core/spi_flash_program_erase_sequencer_unit.sv
// SPI NOR flash program/erase sequencer. Each beat on req_bus is either a new request
// (write, write with sector erase, sector erase, chip erase) or the status of the last
// flash operation; each accepted beat yields exactly one beat on rsp_bus naming the next
// flash action, a poll, the end of the request, or no action. One beat is accepted
// per clock while rsp_bus keeps up: the beat lands in the input register, and one
// pass through the step logic then loads its response into the response register,
// together with the sequencing state that each following beat sees, once that
// register is empty or its response is taken. A stalled response leaves room for one
// more beat in the input register and then holds off req_bus. The poll limit register
// sits at byte address 0 of the register port and resets to 12000.
module spi_flash_program_erase_sequencer_unit (
   input  logic                             clock,
   input  logic                             reset,
   sfpes_req_if.sink                        req_bus,
   sfpes_rsp_if.source                      rsp_bus,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sfpes_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sfpes_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sfpes_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);

   logic [sfpes_pkg::RETRY_W-1:0] poll_limit;
   logic                          item_valid;
   sfpes_pkg::req_item_type       item;
   logic                          take;

   sfpes_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .poll_limit  (poll_limit)
   );

   sfpes_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   sfpes_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .poll_limit  (poll_limit),
      .item_valid  (item_valid),
      .item        (item),
      .take        (take),
      .rsp_bus     (rsp_bus)
   );

endmodule

>>> rtl/core/sfpes_checker.sv
module sfpes_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [sfpes_pkg::ACT_W-1:0]      rsp_action,
   input logic [sfpes_pkg::LEN_W-1:0]      rsp_op_length,
   input logic [sfpes_pkg::ADDR_W-1:0]     rsp_source_offset,
   input logic                             csr_psel,
   input logic                             csr_penable,
   input logic                             csr_pwrite,
   input logic                             csr_pready,
   input logic [sfpes_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [sfpes_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input logic [sfpes_pkg::CSR_DATA_W-1:0] csr_prdata
);

   localparam int TOP = sfpes_pkg::CSR_ADDR_W - 1;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action != sfpes_pkg::ACT_PROGRAM)
      |-> (rsp_op_length == '0) && (rsp_source_offset == '0))
      else $error("chunk fields set on a non-program action");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == sfpes_pkg::ACT_PROGRAM)
      |-> (rsp_op_length != '0)
          && (rsp_op_length <= sfpes_pkg::LEN_W'(sfpes_pkg::PAGE_BYTES)))
      else $error("program chunk length out of range");

   assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_pready
       && (csr_paddr[TOP] == sfpes_pkg::CSR_IDX_POLL_LIMIT))
      ##1 (csr_psel && !csr_pwrite && (csr_paddr[TOP] == sfpes_pkg::CSR_IDX_POLL_LIMIT))
      |-> csr_prdata[sfpes_pkg::RETRY_W-1:0] == $past(csr_pwdata[sfpes_pkg::RETRY_W-1:0]))
      else $error("poll limit readback mismatch");

endmodule

bind spi_flash_program_erase_sequencer_unit sfpes_checker u_sfpes_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_action        (rsp_bus.action),
   .rsp_op_length     (rsp_bus.op_length),
   .rsp_source_offset (rsp_bus.source_offset),
   .csr_psel          (csr_psel),
   .csr_penable       (csr_penable),
   .csr_pwrite        (csr_pwrite),
   .csr_pready        (csr_pready),
   .csr_paddr         (csr_paddr),
   .csr_pwdata        (csr_pwdata),
   .csr_prdata        (csr_prdata)
);
